[src/brs_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB scaler package
// Shared widths, codes and types for the scaler and its frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int POS_W     = 12;
  localparam int STEP_W    = 24;
  localparam int PROD_W    = POS_W + STEP_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP = 1'd1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_INTERP = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd32768;

  // channel 0 is blue, 1 green, 2 red
  typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

endpackage

`default_nettype wire

[src/bilinear_rgb_scaler_unit.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB scaler
// Source frame store plus a pipelined bilinear interpolator.
// ----------------------------------------------------------------------------
// Takes one word per clock unless out_ready stalls, loads and interpolations
// mixed freely. A load writes one pixel into the frame store and gives no
// result; an interpolate word gives one result, and later words may enter
// before it leaves. The frame store is four banks split by row and column
// parity, each (MAX_HEIGHT+1)/2 x (MAX_WIDTH+1)/2 entries, so the four
// neighbours come out of one read. Writes and reads are issued from the same
// pipeline stage in word order, so a load is seen by any later interpolate.
// The store is not cleared: a pixel never loaded reads undefined. Step
// registers must be written only while the block is idle; it is not enforced.
`default_nettype none

module bilinear_rgb_scaler_unit
  import brs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [STEP_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 action,
  input  wire logic [POS_W-1:0]     pos_row,
  input  wire logic [POS_W-1:0]     pos_col,
  input  wire logic [PIX_W-1:0]     in_blue,
  input  wire logic [PIX_W-1:0]     in_green,
  input  wire logic [PIX_W-1:0]     in_red,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_blue,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_red
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int F   = FRAC_BITS;
  localparam int IW  = PROD_W - F;
  localparam int TW  = PIX_W + F;
  localparam int TPW = TW + 1;
  localparam int VW  = PIX_W + 2 * F;
  localparam int VPW = TW + F + 1;

  localparam logic [F:0]    ONE  = (F + 1)'(1) << F;
  localparam logic [VW-1:0] HALF = VW'(1) << (2 * F - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

  // configuration
  logic [STEP_W-1:0] row_step, col_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_step <= STEP_RESET;
      col_step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_STEP: row_step <= cfg_data;
        CFG_COL_STEP: col_step <= cfg_data;
      endcase
    end
  end

  // stage valids and readiness
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;

  assign g_rdy = !g_vld || out_ready;
  assign f_rdy = !f_vld || g_rdy;
  assign e_rdy = !e_vld || f_rdy;
  assign d_rdy = !d_vld || e_rdy;
  assign c_rdy = !c_vld || d_rdy;
  assign b_rdy = !b_vld || c_rdy;
  assign a_rdy = !a_vld || b_rdy;
  assign in_ready = a_rdy;

  // A: input register
  logic             a_act;
  logic [POS_W-1:0] a_row, a_col;
  pixel_t           a_pix;
  // B: scaled positions
  logic              b_act;
  logic [POS_W-1:0]  b_row, b_col;
  logic [PROD_W-1:0] b_rprod, b_cprod;
  pixel_t            b_pix;
  // C: clamped indices, store access
  logic          c_act, c_wen;
  logic [RW-1:0] c_r0, c_r1;
  logic [CW-1:0] c_c0, c_c1;
  logic [F-1:0]  c_fr, c_fc;
  pixel_t        c_pix;
  // D: neighbour pixels out of the store
  logic [F-1:0] d_fr, d_fc;
  logic [F:0]   d_wr0, d_wc0;
  pixel_t       p00, p01, p10, p11;
  // E: horizontal blend
  logic [NUM_CH-1:0][TW-1:0] e_top, e_bot;
  logic [F-1:0]              e_fr;
  logic [F:0]                e_wr0;
  // F: vertical products
  logic [NUM_CH-1:0][VW-1:0] f_pt, f_pb;
  // G: output register
  pixel_t g_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else begin
      if (a_rdy) a_vld <= in_valid;
      if (b_rdy) b_vld <= a_vld;
      if (c_rdy) c_vld <= b_vld;
      // loads end at the store write
      if (d_rdy) d_vld <= c_vld && c_act == ACT_INTERP;
      if (e_rdy) e_vld <= d_vld;
      if (f_rdy) f_vld <= e_vld;
      if (g_rdy) g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_act <= action;
      a_row <= pos_row;
      a_col <= pos_col;
      a_pix <= {in_red, in_green, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld && b_rdy) begin
      b_act   <= a_act;
      b_row   <= a_row;
      b_col   <= a_col;
      b_pix   <= a_pix;
      b_rprod <= PROD_W'(a_row) * PROD_W'(row_step);
      b_cprod <= PROD_W'(a_col) * PROD_W'(col_step);
    end
  end

  logic [IW-1:0] r_int, c_int;
  logic [RW-1:0] r0, r1;
  logic [CW-1:0] c0, c1;
  logic          ld_ok;

  always_comb begin
    r_int = b_rprod[PROD_W-1:F];
    c_int = b_cprod[PROD_W-1:F];
    r0    = (r_int > IW'(MAX_HEIGHT - 1)) ? LAST_ROW : RW'(r_int);
    c0    = (c_int > IW'(MAX_WIDTH - 1)) ? LAST_COL : CW'(c_int);
    r1    = (r0 == LAST_ROW) ? r0 : r0 + 1'b1;
    c1    = (c0 == LAST_COL) ? c0 : c0 + 1'b1;
    ld_ok = (32'(b_row) < 32'(MAX_HEIGHT)) && (32'(b_col) < 32'(MAX_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (b_vld && c_rdy) begin
      c_act <= b_act;
      c_wen <= ld_ok;
      c_pix <= b_pix;
      c_fr  <= b_rprod[F-1:0];
      c_fc  <= b_cprod[F-1:0];
      c_r1  <= r1;
      c_c1  <= c1;
      if (b_act == ACT_LOAD) begin
        c_r0 <= RW'(b_row);
        c_c0 <= CW'(b_col);
      end else begin
        c_r0 <= r0;
        c_c0 <= c0;
      end
    end
  end

  store_ctl_t st_ctl;

  assign st_ctl.wr = c_vld && d_rdy && c_act == ACT_LOAD && c_wen;
  assign st_ctl.rd = c_vld && d_rdy && c_act == ACT_INTERP;

  brs_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .row0  (c_r0),
    .row1  (c_r1),
    .col0  (c_c0),
    .col1  (c_c1),
    .wr_pix(c_pix),
    .p00   (p00),
    .p01   (p01),
    .p10   (p10),
    .p11   (p11)
  );

  always_ff @(posedge clk) begin
    if (st_ctl.rd) begin
      d_fr  <= c_fr;
      d_fc  <= c_fc;
      d_wr0 <= ONE - {1'b0, c_fr};
      d_wc0 <= ONE - {1'b0, c_fc};
    end
  end

  always_ff @(posedge clk) begin
    if (d_vld && e_rdy) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        e_top[ch] <= TW'(TPW'(p00[ch]) * TPW'(d_wc0) + TPW'(p01[ch]) * TPW'(d_fc));
        e_bot[ch] <= TW'(TPW'(p10[ch]) * TPW'(d_wc0) + TPW'(p11[ch]) * TPW'(d_fc));
      end
      e_fr  <= d_fr;
      e_wr0 <= d_wr0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_vld && f_rdy) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        f_pt[ch] <= VW'(VPW'(e_top[ch]) * VPW'(e_wr0));
        f_pb[ch] <= VW'(VPW'(e_bot[ch]) * VPW'(e_fr));
      end
    end
  end

  logic [NUM_CH-1:0][VW-1:0] g_sum;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      // nearest, ties up; never exceeds 255
      g_sum[ch] = f_pt[ch] + f_pb[ch] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (f_vld && g_rdy) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        g_pix[ch] <= g_sum[ch][VW-1:2*F];
      end
    end
  end

  assign out_valid = g_vld;
  assign out_blue  = g_pix[0];
  assign out_green = g_pix[1];
  assign out_red   = g_pix[2];

  // neighbour indices stay inside the store and at most one apart
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (c_vld && c_act == ACT_INTERP) |->
      ((c_r1 == c_r0 || c_r1 == c_r0 + 1'b1) &&
       (c_c1 == c_c0 || c_c1 == c_c0 + 1'b1) &&
       32'(c_r1) < 32'(MAX_HEIGHT) && 32'(c_c1) < 32'(MAX_WIDTH)))
    else $error("neighbour index out of range");

  // a stalled read word must keep its store data
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (d_vld && !e_rdy) |=> ($stable(p00) && $stable(d_fr) && $stable(d_fc)))
    else $error("store read word lost while stalled");

  // store never written and read in the same cycle
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    st_ctl.rd |-> !st_ctl.wr && c_vld)
    else $error("store write and read together");

endmodule

`default_nettype wire

[src/brs_store.sv]
// ----------------------------------------------------------------------------
// Bilinear RGB scaler frame store
// Four banks split by row and column parity; one pixel write or a read of
// the four neighbours per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_store
  import brs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                          clk,
  input  wire store_ctl_t                    ctl,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] row0,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] row1,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col0,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col1,
  input  wire pixel_t                        wr_pix,
  output pixel_t                             p00,
  output pixel_t                             p01,
  output pixel_t                             p10,
  output pixel_t                             p11
);

  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [AW-1:0] bank_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(32'(r >> 1) * 32'(BANK_COLS) + 32'(c >> 1));
  endfunction

  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_bank;
  pixel_t        q [4];
  logic          r0p, r1p, c0p, c1p;

  assign wr_addr = bank_addr(row0, col0);
  assign wr_bank = {row0[0], col0[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'(b >> 1);
    localparam logic PC = 1'(b & 1);

    logic [RW-1:0] rrow;
    logic [CW-1:0] rcol;
    logic [AW-1:0] raddr;
    pixel_t        mem [BANK_DEPTH];

    // the row of this parity among the two neighbours; when both clamp to
    // one row the other parity is unused
    assign rrow  = (row0[0] == PR) ? row0 : row1;
    assign rcol  = (col0[0] == PC) ? col0 : col1;
    assign raddr = bank_addr(rrow, rcol);

    always_ff @(posedge clk) begin
      if (ctl.wr && wr_bank == 2'(b)) begin
        mem[wr_addr] <= wr_pix;
      end
      if (ctl.rd) begin
        q[b] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      r0p <= row0[0];
      r1p <= row1[0];
      c0p <= col0[0];
      c1p <= col1[0];
    end
  end

  assign p00 = q[{r0p, c0p}];
  assign p01 = q[{r0p, c1p}];
  assign p10 = q[{r1p, c0p}];
  assign p11 = q[{r1p, c1p}];

endmodule

`default_nettype wire
